FILE: rtl/ata_pkg.sv
// package for the accelerometer tilt angle block
// types, constants and the cordic arctangent table; no dependencies
package ata_pkg;

    localparam int MAP_BITS   = 11;
    localparam int ANGLE_BITS = 16;
    localparam int TABLE_LEN  = 24;
    localparam int Z_BITS     = 25;

    localparam logic [9:0] RAW_MIN_RESET = 10'd403;
    localparam logic [9:0] RAW_MAX_RESET = 10'd625;

    localparam logic [ANGLE_BITS-1:0] DEG_0   = 16'd0;
    localparam logic [ANGLE_BITS-1:0] DEG_90  = 16'd9000;
    localparam logic [ANGLE_BITS-1:0] DEG_180 = 16'd18000;
    localparam logic [ANGLE_BITS-1:0] DEG_270 = 16'd27000;
    localparam logic [ANGLE_BITS-1:0] DEG_360 = 16'd36000;

    localparam logic signed [Z_BITS-1:0] HALF_TURN = 25'sd4608000;
    localparam logic signed [Z_BITS-1:0] FULL_TURN = 25'sd9216000;

    typedef enum logic {
        REG_RAW_MIN = 1'b0,
        REG_RAW_MAX = 1'b1
    } t_reg_index;

    // special case classification carried down the cordic row
    typedef enum logic [2:0] {
        SPEC_NONE,
        SPEC_P0_QPOS,
        SPEC_P0_QNEG,
        SPEC_Q0_PPOS,
        SPEC_Q0_PNEG
    } t_spec;

    typedef struct packed {
        logic signed [MAP_BITS-1:0] p;
        logic signed [MAP_BITS-1:0] q;
    } t_pair;

    function automatic logic signed [Z_BITS-1:0] atan_step(input int i);
        logic signed [Z_BITS-1:0] r;
        case (i)
            0: r = 25'sd1152000;  1: r = 25'sd680065;  2: r = 25'sd359328;
            3: r = 25'sd182400;   4: r = 25'sd91554;   5: r = 25'sd45822;
            6: r = 25'sd22916;    7: r = 25'sd11459;   8: r = 25'sd5730;
            9: r = 25'sd2865;     10: r = 25'sd1432;   11: r = 25'sd716;
            12: r = 25'sd358;     13: r = 25'sd179;    14: r = 25'sd90;
            15: r = 25'sd45;      16: r = 25'sd22;     17: r = 25'sd11;
            18: r = 25'sd6;       19: r = 25'sd3;      20: r = 25'sd1;
            21: r = 25'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/ata_stream_if.sv
// valid/ready channel interface carrying one item payload
// depends on nothing
interface ata_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ata_map_cell.sv
// one cell of the restoring divider row for the axis mapping
// depends on nothing
module ata_map_cell #(
    parameter int NUM_BITS = 20,
    parameter int DEN_BITS = 11,
    parameter int STEP     = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic                i_neg,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    input  logic [NUM_BITS-1:0] i_quo,
    input  logic [NUM_BITS+DEN_BITS-1:0] i_rem,
    output logic                o_neg,
    output logic [NUM_BITS-1:0] o_num,
    output logic [DEN_BITS-1:0] o_den,
    output logic [NUM_BITS-1:0] o_quo,
    output logic [NUM_BITS+DEN_BITS-1:0] o_rem
);
    localparam int RB = NUM_BITS + DEN_BITS;
    localparam int BIT = NUM_BITS - 1 - STEP;

    logic [RB-1:0]       n_rem;
    logic [NUM_BITS-1:0] n_quo;
    logic [RB-1:0]       w_shift;

    always_comb begin
        w_shift = {i_rem[RB-2:0], i_num[BIT]};
        n_quo   = i_quo;
        if (w_shift >= {{NUM_BITS{1'b0}}, i_den}) begin
            n_rem      = w_shift - {{NUM_BITS{1'b0}}, i_den};
            n_quo[BIT] = 1'b1;
        end else begin
            n_rem = w_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_neg <= i_neg;
            o_num <= i_num;
            o_den <= i_den;
            o_quo <= n_quo;
            o_rem <= n_rem;
        end
    end
endmodule

FILE: rtl/ata_cordic_cell.sv
// one vectoring cordic rotation cell with its special case side band
// depends on ata_pkg
module ata_cordic_cell #(
    parameter int VEC_BITS = 30,
    parameter int STEP     = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [VEC_BITS-1:0]           i_x,
    input  logic signed [VEC_BITS-1:0]           i_y,
    input  logic signed [ata_pkg::Z_BITS-1:0]    i_z,
    input  ata_pkg::t_spec                       i_spec,
    output logic signed [VEC_BITS-1:0]           o_x,
    output logic signed [VEC_BITS-1:0]           o_y,
    output logic signed [ata_pkg::Z_BITS-1:0]    o_z,
    output ata_pkg::t_spec                       o_spec
);
    localparam logic signed [ata_pkg::Z_BITS-1:0] A = ata_pkg::atan_step(STEP);

    logic signed [VEC_BITS-1:0] w_dx, w_dy;

    // arithmetic shift is the floor division by a power of two
    assign w_dx = i_y >>> STEP;
    assign w_dy = i_x >>> STEP;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_spec <= i_spec;
            if (!i_y[VEC_BITS-1]) begin
                o_x <= i_x + w_dx;
                o_y <= i_y - w_dy;
                o_z <= i_z + A;
            end else begin
                o_x <= i_x - w_dx;
                o_y <= i_y + w_dy;
                o_z <= i_z - A;
            end
        end
    end
endmodule

FILE: rtl/ata_cordic_row.sv
// one pair to one angle: entry cell, row of cordic cells and the final rounding
// depends on ata_pkg and ata_cordic_cell
module ata_cordic_row #(
    parameter int STAGES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  ata_pkg::t_pair                     i_pair,
    output logic [ata_pkg::ANGLE_BITS-1:0]     o_angle
);
    localparam int VB = ata_pkg::MAP_BITS + 16 + 3;

    logic signed [VB-1:0]             w_x [STAGES+1];
    logic signed [VB-1:0]             w_y [STAGES+1];
    logic signed [ata_pkg::Z_BITS-1:0] w_z [STAGES+1];
    ata_pkg::t_spec                   w_s [STAGES+1];

    logic signed [VB-1:0]              r_x0, r_y0;
    logic signed [ata_pkg::Z_BITS-1:0] r_z0;
    ata_pkg::t_spec                    r_s0;

    logic signed [ata_pkg::MAP_BITS:0] w_p, w_q;
    ata_pkg::t_spec n_spec;

    always_comb begin
        w_p = {i_pair.p[ata_pkg::MAP_BITS-1], i_pair.p};
        w_q = {i_pair.q[ata_pkg::MAP_BITS-1], i_pair.q};
        if (i_pair.p == '0)
            n_spec = (i_pair.q[ata_pkg::MAP_BITS-1] || i_pair.q == '0) ?
                     ata_pkg::SPEC_P0_QNEG : ata_pkg::SPEC_P0_QPOS;
        else if (i_pair.q == '0)
            n_spec = i_pair.p[ata_pkg::MAP_BITS-1] ?
                     ata_pkg::SPEC_Q0_PNEG : ata_pkg::SPEC_Q0_PPOS;
        else
            n_spec = ata_pkg::SPEC_NONE;
    end

    // entry register: fold the left half plane by half a turn
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0 <= n_spec;
            if (w_q[ata_pkg::MAP_BITS]) begin
                r_x0 <= {{(VB-ata_pkg::MAP_BITS-17){1'b0}}, -w_q, 16'd0};
                r_y0 <= {{(VB-ata_pkg::MAP_BITS-17){w_p[ata_pkg::MAP_BITS]^1'b1}},
                         -w_p, 16'd0};
                r_z0 <= ata_pkg::HALF_TURN;
            end else begin
                r_x0 <= {{(VB-ata_pkg::MAP_BITS-17){1'b0}}, w_q, 16'd0};
                r_y0 <= {{(VB-ata_pkg::MAP_BITS-17){w_p[ata_pkg::MAP_BITS]}},
                         w_p, 16'd0};
                r_z0 <= '0;
            end
        end
    end

    assign w_x[0] = r_x0;
    assign w_y[0] = r_y0;
    assign w_z[0] = r_z0;
    assign w_s[0] = r_s0;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        ata_cordic_cell #(.VEC_BITS(VB), .STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_x    (w_x[g]),
            .i_y    (w_y[g]),
            .i_z    (w_z[g]),
            .i_spec (w_s[g]),
            .o_x    (w_x[g+1]),
            .o_y    (w_y[g+1]),
            .o_z    (w_z[g+1]),
            .o_spec (w_s[g+1])
        );
    end

    logic signed [ata_pkg::Z_BITS:0] w_phi, w_r;
    logic [ata_pkg::ANGLE_BITS-1:0]  n_angle;

    always_comb begin
        w_phi = {w_z[STAGES][ata_pkg::Z_BITS-1], w_z[STAGES]};
        if (w_phi <= 0)
            w_phi = w_phi + {1'b0, ata_pkg::FULL_TURN};
        w_r = (w_phi + 26'sd128) >>> 8;
        if (w_r < 0)
            n_angle = ata_pkg::DEG_0;
        else if (w_r > 26'sd36000)
            n_angle = ata_pkg::DEG_360;
        else
            n_angle = w_r[ata_pkg::ANGLE_BITS-1:0];
        case (w_s[STAGES])
            ata_pkg::SPEC_P0_QPOS: n_angle = ata_pkg::DEG_360;
            ata_pkg::SPEC_P0_QNEG: n_angle = ata_pkg::DEG_180;
            ata_pkg::SPEC_Q0_PPOS: n_angle = ata_pkg::DEG_90;
            ata_pkg::SPEC_Q0_PNEG: n_angle = ata_pkg::DEG_270;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en)
            o_angle <= n_angle;
    end
endmodule

FILE: rtl/accel_tilt_angles.sv
// top level of the accelerometer tilt angle block
// depends on ata_pkg, ata_stream_if, ata_map_cell, ata_cordic_row
//
// channel  | dir | payload                                    | handshake
// s_in     | in  | x_sample, y_sample, z_sample               | valid/ready
// m_out    | out | x_angle, y_angle, z_angle, config_error     | valid/ready
// config   | in  | i_cfg_we, i_cfg_idx, i_cfg_data            | write enable
//
// one item enters per cycle while the output is not stalled; an item passes the input stage,
// the (SAMPLE_BITS+8) divider cells, the map register, then the cordic entry, cells and rounding
// the whole pipeline advances as one when the output stage can move
// synchronous active low reset clears the valid bits and loads the default calibration
// a stalled output freezes every stage, so ready falls only under stall
module accel_tilt_angles #(
    parameter int SAMPLE_BITS   = 10,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    ata_stream_if.sink             s_in,
    ata_stream_if.source           m_out,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [SAMPLE_BITS-1:0] i_cfg_data
);
    localparam int SB  = SAMPLE_BITS;
    localparam int NB  = SB + 8;        // |v-min|*180 fits
    localparam int DB  = SB + 1;
    localparam int DIV = NB;
    localparam int LAT = 1 + DIV + 1 + 1 + CORDIC_STAGES + 1;
    localparam int MB  = ata_pkg::MAP_BITS;

    // calibration registers
    logic [SB-1:0] r_raw_min, r_raw_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_min <= SB'(ata_pkg::RAW_MIN_RESET);
            r_raw_max <= SB'(ata_pkg::RAW_MAX_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ata_pkg::REG_RAW_MIN: r_raw_min <= i_cfg_data;
                ata_pkg::REG_RAW_MAX: r_raw_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance: everything moves unless a result is held back
    logic w_en;
    logic [LAT-1:0] r_vld;
    assign w_en        = !m_out.valid || m_out.ready;
    assign s_in.ready  = w_en;
    assign m_out.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= '0;
        else if (w_en)
            r_vld <= {r_vld[LAT-2:0], s_in.valid};
    end

    // input stage: magnitude of (v-min)*180, sign, and the divisor
    logic [SB-1:0] w_smp [3];
    assign w_smp[0] = s_in.data.x_sample[SB-1:0];
    assign w_smp[1] = s_in.data.y_sample[SB-1:0];
    assign w_smp[2] = s_in.data.z_sample[SB-1:0];

    logic          r_err [DIV+2];
    logic [DB-1:0] r_den;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_err[0] <= (r_raw_max <= r_raw_min);
            r_den    <= DB'(r_raw_max) - DB'(r_raw_min);
            for (int k = 1; k < DIV + 2; k++)
                r_err[k] <= r_err[k-1];
        end
    end

    ata_pkg::t_pair w_pair [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic          r_neg;
        logic [NB-1:0] r_num;
        logic          w_neg  [DIV+1];
        logic [NB-1:0] w_num  [DIV+1];
        logic [DB-1:0] w_den  [DIV+1];
        logic [NB-1:0] w_quo  [DIV+1];
        logic [NB+DB-1:0] w_rem [DIV+1];
        logic [SB-1:0] w_mag;

        assign w_mag = (w_smp[a] >= r_raw_min) ? w_smp[a] - r_raw_min
                                               : r_raw_min - w_smp[a];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_neg <= (w_smp[a] < r_raw_min);
                r_num <= NB'(w_mag) * NB'(180);
            end
        end

        assign w_neg[0] = r_neg;
        assign w_num[0] = r_num;
        assign w_den[0] = r_den;
        assign w_quo[0] = '0;
        assign w_rem[0] = '0;

        for (genvar c = 0; c < DIV; c++) begin : g_div
            ata_map_cell #(.NUM_BITS(NB), .DEN_BITS(DB), .STEP(c)) u_cell (
                .i_clk (i_clk), .i_en (w_en),
                .i_neg (w_neg[c]), .i_num (w_num[c]), .i_den (w_den[c]),
                .i_quo (w_quo[c]), .i_rem (w_rem[c]),
                .o_neg (w_neg[c+1]), .o_num (w_num[c+1]), .o_den (w_den[c+1]),
                .o_quo (w_quo[c+1]), .o_rem (w_rem[c+1])
            );
        end

        // signed quotient minus ninety, saturated
        logic signed [NB+1:0] w_m;
        logic signed [MB-1:0] r_map;
        always_comb begin
            w_m = w_neg[DIV] ? -$signed({2'b00, w_quo[DIV]})
                             : $signed({2'b00, w_quo[DIV]});
            w_m = w_m - (NB+2)'(90);
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (w_m < -(NB+2)'(1024))
                    r_map <= -11'sd1024;
                else if (w_m > (NB+2)'(1023))
                    r_map <= 11'sd1023;
                else
                    r_map <= w_m[MB-1:0];
            end
        end
    end

    assign w_pair[0] = '{p: g_axis[1].r_map, q: g_axis[2].r_map};
    assign w_pair[1] = '{p: g_axis[0].r_map, q: g_axis[2].r_map};
    assign w_pair[2] = '{p: g_axis[1].r_map, q: g_axis[0].r_map};

    logic [ata_pkg::ANGLE_BITS-1:0] w_ang [3];
    for (genvar a = 0; a < 3; a++) begin : g_row
        ata_cordic_row #(.STAGES(CORDIC_STAGES)) u_row (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_pair  (w_pair[a]),
            .o_angle (w_ang[a])
        );
    end

    // error flag rides alongside through the cordic rows
    logic r_err_c [CORDIC_STAGES+2];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_err_c[0] <= r_err[DIV+1];
            for (int k = 1; k < CORDIC_STAGES + 2; k++)
                r_err_c[k] <= r_err_c[k-1];
        end
    end

    logic w_e;
    assign w_e = r_err_c[CORDIC_STAGES+1];
    assign m_out.data.x_angle      = w_e ? ata_pkg::DEG_0 : w_ang[0];
    assign m_out.data.y_angle      = w_e ? ata_pkg::DEG_0 : w_ang[1];
    assign m_out.data.z_angle      = w_e ? ata_pkg::DEG_0 : w_ang[2];
    assign m_out.data.config_error = w_e;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid)
        else $error("result lost under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_out.valid |-> s_in.ready)
        else $error("input blocked with empty output");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && m_out.data.config_error |-> m_out.data.x_angle == 16'd0)
        else $error("angle not zero on config error");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> m_out.data.z_angle <= 16'd36000)
        else $error("angle out of range");
`endif
endmodule

FILE: tb/sv/tb_ata_types_pkg.sv
`timescale 1ns / 1ps
// item types carried by the stream channels of the tilt angle testbench
// depends on nothing; field names follow the block's channel payloads
package tb_ata_types_pkg;

    typedef struct packed {
        logic [9:0] x_sample;
        logic [9:0] y_sample;
        logic [9:0] z_sample;
    } t_sample_item;

    typedef struct packed {
        logic [15:0] x_angle;
        logic [15:0] y_angle;
        logic [15:0] z_angle;
        logic        config_error;
    } t_angle_item;

endpackage

FILE: tb/sv/tb_accel_tilt_angles.sv
`timescale 1ns / 1ps
// self-checking testbench for accel_tilt_angles: samples in, tilt angles out
// depends on ata_pkg, ata_stream_if, tb_ata_types_pkg and the block itself
module tb_accel_tilt_angles;

    localparam int LATENCY    = 1 + (10 + 8) + 1 + 1 + 16 + 1;
    localparam int LONG_HOLD  = 300;
    localparam int IDLE_LIMIT = 5000;
    localparam int N_STAGES   = 16;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [9:0] i_cfg_data;

    ata_stream_if #(.T(tb_ata_types_pkg::t_sample_item)) s_in ();
    ata_stream_if #(.T(tb_ata_types_pkg::t_angle_item))  m_out ();

    accel_tilt_angles u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_in       (s_in),
        .m_out      (m_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor copy of the calibration
    longint cal_min = 403;
    longint cal_max = 625;

    tb_ata_types_pkg::t_angle_item angles_due[$];
    int          n_errors    = 0;
    bit          gaps_on     = 1;
    int          holds_asked = 0;
    int          holds_done  = 0;
    int          quiet_cycles = 0;

    // arctangent of 2^-i in 1/256 hundredths of a degree
    const longint atan_lut[24] = '{
        1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
        5730, 2865, 1432, 716, 358, 179, 90, 45,
        22, 11, 6, 3, 1, 1, 0, 0
    };

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // linear map of one raw reading, quotient truncated, then saturated
    function automatic longint map_reading(input logic [9:0] v);
        longint m;
        m = ((longint'(v) - cal_min) * 180) / (cal_max - cal_min) - 90;
        if (m < -1024) m = -1024;
        if (m > 1023) m = 1023;
        return m;
    endfunction

    // atan2(-p,-q)+180 in hundredths, cordic in vectoring mode
    function automatic logic [15:0] tilt_of(input longint p, input longint q);
        longint vx, vy, vz, dx, dy, phi, r;
        if (p == 0) return (q > 0) ? 16'd36000 : 16'd18000;
        if (q == 0) return (p > 0) ? 16'd9000 : 16'd27000;
        if (q < 0) begin
            vx = -q * 65536;
            vy = -p * 65536;
            vz = 18000 * 256;
        end else begin
            vx = q * 65536;
            vy = p * 65536;
            vz = 0;
        end
        for (int i = 0; i < N_STAGES; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx = vx + dx;
                vy = vy - dy;
                vz = vz + ((i < 24) ? atan_lut[i] : 0);
            end else begin
                vx = vx - dx;
                vy = vy + dy;
                vz = vz - ((i < 24) ? atan_lut[i] : 0);
            end
        end
        phi = vz;
        if (phi <= 0) phi += 36000 * 256;
        r = (phi + 128) >>> 8;
        if (r < 0) r = 0;
        if (r > 36000) r = 36000;
        return r[15:0];
    endfunction

    function automatic tb_ata_types_pkg::t_angle_item predict_angles(
        input tb_ata_types_pkg::t_sample_item s);
        tb_ata_types_pkg::t_angle_item a;
        longint mx, my, mz;
        if (cal_max <= cal_min) begin
            a = '0;
            a.config_error = 1'b1;
            return a;
        end
        mx = map_reading(s.x_sample);
        my = map_reading(s.y_sample);
        mz = map_reading(s.z_sample);
        a.x_angle      = tilt_of(my, mz);
        a.y_angle      = tilt_of(mx, mz);
        a.z_angle      = tilt_of(my, mx);
        a.config_error = 1'b0;
        return a;
    endfunction

    // lowest raw reading that maps to the given level, or a random one
    function automatic logic [9:0] reading_for(input longint level);
        if (cal_max > cal_min)
            for (int v = 0; v < 1024; v++)
                if (map_reading(v[9:0]) == level) return v[9:0];
        return 10'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // pacing helpers
    // ------------------------------------------------------------------

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one item and wait until it is accepted
    task automatic send_sample(input tb_ata_types_pkg::t_sample_item s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_in.valid <= 1'b1;
        s_in.data  <= s;
        @(posedge i_clk);
        while (!s_in.ready) @(posedge i_clk);
        angles_due.push_back(predict_angles(s));
    endtask

    task automatic send_xyz(input logic [9:0] x, input logic [9:0] y, input logic [9:0] z);
        tb_ata_types_pkg::t_sample_item s;
        s.x_sample = x;
        s.y_sample = y;
        s.z_sample = z;
        send_sample(s);
    endtask

    task automatic wait_drained();
        s_in.valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
    endtask

    // calibration only changes with the pipeline empty
    task automatic write_calibration(input logic [9:0] lo, input logic [9:0] hi);
        wait_drained();
        repeat (LATENCY + 4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ata_pkg::REG_RAW_MIN;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= ata_pkg::REG_RAW_MAX;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cal_min = lo;
        cal_max = hi;
    endtask

    // random reading, biased towards the level-zero point and the rails
    function automatic logic [9:0] random_reading(input logic [9:0] zero_pt);
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return zero_pt;
        if (r < 25) return 10'd0;
        if (r < 30) return 10'd1023;
        if (r < 40) return 10'(zero_pt + $urandom_range(0, 6) - 3);
        return 10'($urandom);
    endfunction

    task automatic random_burst(input int n_items);
        logic [9:0] zp;
        zp = reading_for(0);
        repeat (n_items)
            send_xyz(random_reading(zp), random_reading(zp), random_reading(zp));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // rails, level-zero axes, levels of plus and minus ninety, both-zero pair
    task automatic test_directed();
        logic [9:0] z0, lo, hi;
        z0 = reading_for(0);
        lo = reading_for(-90);
        hi = reading_for(90);
        send_xyz(z0, z0, z0);
        send_xyz(10'd0, 10'd0, 10'd0);
        send_xyz(10'd1023, 10'd1023, 10'd1023);
        send_xyz(z0, z0, hi);
        send_xyz(z0, z0, lo);
        send_xyz(z0, hi, z0);
        send_xyz(z0, lo, z0);
        send_xyz(hi, z0, z0);
        send_xyz(lo, z0, z0);
        send_xyz(hi, hi, hi);
        send_xyz(lo, lo, lo);
        send_xyz(hi, lo, hi);
        send_xyz(lo, hi, lo);
        send_xyz(10'd1023, 10'd0, z0);
        send_xyz(10'd0, 10'd1023, 10'd1023);
        send_xyz(10'd1023, z0, 10'd0);
        send_xyz(10'h2AA, 10'h155, 10'h3FF);
        send_xyz(10'h155, 10'h2AA, 10'h000);
    endtask

    // a spread of calibrations, the widest and narrowest spans among them
    task automatic test_calibrations();
        write_calibration(10'd0, 10'd1023);
        random_burst(130);
        write_calibration(10'd0, 10'd1);
        random_burst(60);
        write_calibration(10'd1022, 10'd1023);
        random_burst(60);
        write_calibration(10'd500, 10'd501);
        random_burst(60);
        write_calibration(10'd256, 10'd768);
        random_burst(130);
        write_calibration(10'd341, 10'd682);
        random_burst(130);
        write_calibration(10'($urandom_range(0, 500)), 10'($urandom_range(520, 1023)));
        random_burst(130);
    endtask

    // span not positive: error flag and zero angles
    task automatic test_bad_calibration();
        write_calibration(10'd600, 10'd600);
        random_burst(20);
        write_calibration(10'd1023, 10'd0);
        random_burst(20);
        write_calibration(10'd512, 10'd511);
        random_burst(20);
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_backpressure();
        write_calibration(10'd403, 10'd625);
        gaps_on = 0;
        holds_asked++;
        random_burst(100);
        gaps_on = 1;
        // sender pauses until every expected result is back
        wait_drained();
        random_burst(120);
        // stretch with no gaps on either side for a while
        gaps_on = 0;
        random_burst(60);
        gaps_on = 1;
    endtask

    // ------------------------------------------------------------------
    // receiver side and checking
    // ------------------------------------------------------------------

    initial begin
        int stall;
        m_out.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (holds_done != holds_asked) begin
                holds_done++;
                m_out.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_out.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                m_out.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        tb_ata_types_pkg::t_angle_item want;
        tb_ata_types_pkg::t_angle_item got;
        if (i_rst_n && m_out.valid && m_out.ready) begin
            got = m_out.data;
            if (angles_due.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                want = angles_due.pop_front();
                if (got.x_angle !== want.x_angle)
                    report_mismatch("x_angle", got.x_angle, want.x_angle);
                if (got.y_angle !== want.y_angle)
                    report_mismatch("y_angle", got.y_angle, want.y_angle);
                if (got.z_angle !== want.z_angle)
                    report_mismatch("z_angle", got.z_angle, want.z_angle);
                if (got.config_error !== want.config_error)
                    report_mismatch("config_error", got.config_error, want.config_error);
            end
        end
    end

    // watchdog: too long with nothing accepted on either side
    always @(posedge i_clk) begin
        if ((s_in.valid && s_in.ready) || (m_out.valid && m_out.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = ata_pkg::REG_RAW_MIN;
        i_cfg_data = '0;
        s_in.valid = 1'b0;
        s_in.data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        random_burst(100);
        test_calibrations();
        test_bad_calibration();
        test_backpressure();

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0 && angles_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
